// ----- rtl/lmr_pkg.sv -----
package lmr_pkg;

    localparam int SLOTS       = 4;
    localparam int MSG_BYTES   = 1024;

    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int POS_W       = $clog2(MSG_BYTES + 1);
    localparam int BYTE_W      = $clog2(MSG_BYTES);
    localparam int STORE_AW    = 1 + SLOT_W + BYTE_W;
    localparam int STORE_DEPTH = 2 * (2 ** SLOT_W) * (2 ** BYTE_W);
    localparam int LEN_AW      = 1 + SLOT_W;
    localparam int LEN_DEPTH   = 2 * (2 ** SLOT_W);

    localparam logic [CNT_W-1:0]  SLOTS_C     = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(SLOTS - 1);
    localparam logic [POS_W-1:0]  MSG_BYTES_C = POS_W'(MSG_BYTES);

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic       command;
        logic       channel;
        logic [7:0] data_in;
        logic       end_of_message;
    } t_req;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_byte;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [STORE_AW-1:0] raddr;
    } t_store_port;

    typedef struct packed {
        logic              we;
        logic [LEN_AW-1:0] waddr;
        logic [POS_W-1:0]  wdata;
        logic [LEN_AW-1:0] raddr;
    } t_len_port;

endpackage

// ----- rtl/loopback_message_ring_top.sv -----
// channel   dir  ports                      handshake
// command   in   i_req (command, channel,   accepted when start high and busy low
//                data_in, end_of_message)
// result    out  o_rsp (data_out,           o_valid high for one cycle, always taken
//                last_byte, status)
//
// every word has an accept cycle, which reads the byte store and the length table, and a
// busy cycle, which does the read-modify-write of ring state and memories
// the result strobe comes in the cycle after the busy cycle; a new word may be
// accepted in that same cycle
// synchronous reset clears the state, the valid flag, ring pointers and counts only; memory contents are
// never read before they are written, so there is no clearing pass
// the receiver cannot stall, so results are never held back
module loopback_message_ring_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lmr_pkg::t_req i_req,
    output logic          o_valid,
    output lmr_pkg::t_rsp o_rsp
);

    lmr_pkg::t_store_port       store_port;
    lmr_pkg::t_len_port         len_port;
    logic [7:0]                 store_rdata;
    logic [lmr_pkg::POS_W-1:0]  len_rdata;

    lmr_ram #(
        .WIDTH (8),
        .DEPTH (lmr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_port.we),
        .i_waddr (store_port.waddr),
        .i_wdata (store_port.wdata),
        .i_raddr (store_port.raddr),
        .o_rdata (store_rdata)
    );

    lmr_ram #(
        .WIDTH (lmr_pkg::POS_W),
        .DEPTH (lmr_pkg::LEN_DEPTH)
    ) u_len (
        .i_clk   (i_clk),
        .i_we    (len_port.we),
        .i_waddr (len_port.waddr),
        .i_wdata (len_port.wdata),
        .i_raddr (len_port.raddr),
        .o_rdata (len_rdata)
    );

    lmr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .o_valid       (o_valid),
        .o_rsp         (o_rsp),
        .o_store       (store_port),
        .i_store_rdata (store_rdata),
        .o_len         (len_port),
        .i_len_rdata   (len_rdata)
    );

endmodule

// ----- rtl/lmr_ram.sv -----
module lmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lmr_ctrl.sv -----
module lmr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lmr_pkg::t_req               i_req,
    output logic                        o_valid,
    output lmr_pkg::t_rsp               o_rsp,
    output lmr_pkg::t_store_port        o_store,
    input  logic [7:0]                  i_store_rdata,
    output lmr_pkg::t_len_port          o_len,
    input  logic [lmr_pkg::POS_W-1:0]   i_len_rdata
);

    lmr_pkg::t_state r_state, n_state;

    logic [lmr_pkg::SLOT_W-1:0] r_head  [2];
    logic [lmr_pkg::SLOT_W-1:0] n_head  [2];
    logic [lmr_pkg::CNT_W-1:0]  r_count [2];
    logic [lmr_pkg::CNT_W-1:0]  n_count [2];
    logic [lmr_pkg::POS_W-1:0]  r_wpos  [2];
    logic [lmr_pkg::POS_W-1:0]  n_wpos  [2];
    logic [lmr_pkg::POS_W-1:0]  r_rpos  [2];
    logic [lmr_pkg::POS_W-1:0]  n_rpos  [2];

    lmr_pkg::t_req r_req;
    logic          r_ring;
    lmr_pkg::t_rsp r_rsp, n_rsp;
    logic          r_valid, n_valid;

    logic accept;
    logic exec;
    logic in_ring;

    logic [lmr_pkg::SLOT_W-1:0] head;
    logic [lmr_pkg::SLOT_W-1:0] head_nx;
    logic [lmr_pkg::CNT_W-1:0]  cnt;
    logic [lmr_pkg::CNT_W-1:0]  cnt_new;
    logic [lmr_pkg::POS_W-1:0]  wpos;
    logic [lmr_pkg::POS_W-1:0]  wpos_new;
    logic [lmr_pkg::POS_W-1:0]  rpos;
    logic [lmr_pkg::POS_W-1:0]  rpos_inc;
    logic [lmr_pkg::SLOT_W:0]   slot_sum;
    logic [lmr_pkg::SLOT_W-1:0] slot;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lmr_pkg::S_IDLE: begin
                if (start) begin
                    n_state = lmr_pkg::S_EXEC;
                end
            end
            lmr_pkg::S_EXEC: n_state = lmr_pkg::S_IDLE;
            default:         n_state = lmr_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        case (r_state)
            lmr_pkg::S_IDLE: begin
                busy = 1'b0;
                exec = 1'b0;
            end
            lmr_pkg::S_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start & ~busy;

    // sends land in the opposite ring
    assign in_ring = (i_req.command == lmr_pkg::CMD_SEND) ? ~i_req.channel : i_req.channel;

    assign head     = r_head[r_ring];
    assign cnt      = r_count[r_ring];
    assign wpos     = r_wpos[r_ring];
    assign rpos     = r_rpos[r_ring];
    assign head_nx  = (head == lmr_pkg::SLOT_LAST) ? '0 : head + 1'b1;
    assign rpos_inc = rpos + 1'b1;

    // slot under assembly is head + count wrapped; a drop leaves it at the old head
    assign slot_sum = (lmr_pkg::SLOT_W + 1)'(head) + (lmr_pkg::SLOT_W + 1)'(cnt);
    assign slot     = (slot_sum >= (lmr_pkg::SLOT_W + 1)'(lmr_pkg::SLOTS))
                    ? lmr_pkg::SLOT_W'(slot_sum - (lmr_pkg::SLOT_W + 1)'(lmr_pkg::SLOTS))
                    : lmr_pkg::SLOT_W'(slot_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_wpos  = r_wpos;
        n_rpos  = r_rpos;
        n_rsp   = '0;
        n_valid = 1'b0;
        cnt_new  = cnt;
        wpos_new = wpos;

        // reads are issued at accept from settled ring state
        o_store.raddr = {in_ring, r_head[in_ring], r_rpos[in_ring][lmr_pkg::BYTE_W-1:0]};
        o_len.raddr   = {in_ring, r_head[in_ring]};

        o_store.we    = 1'b0;
        o_store.waddr = {r_ring, slot, wpos[lmr_pkg::BYTE_W-1:0]};
        o_store.wdata = r_req.data_in;
        o_len.we      = 1'b0;
        o_len.waddr   = {r_ring, slot};
        o_len.wdata   = wpos;

        if (exec) begin
            n_valid = 1'b1;
            n_rsp.status = lmr_pkg::ST_OK;
            if (r_req.command == lmr_pkg::CMD_SEND) begin
                if (wpos == '0 && cnt >= lmr_pkg::SLOTS_C) begin
                    n_head[r_ring] = head_nx;
                    n_rpos[r_ring] = '0;
                    cnt_new        = cnt - 1'b1;
                    n_rsp.status   = lmr_pkg::ST_DROP;
                end
                if (wpos < lmr_pkg::MSG_BYTES_C) begin
                    o_store.we = 1'b1;
                    wpos_new   = wpos + 1'b1;
                end else begin
                    n_rsp.status = lmr_pkg::ST_TRUNC;
                end
                if (r_req.end_of_message) begin
                    o_len.we    = 1'b1;
                    o_len.wdata = wpos_new;
                    cnt_new     = cnt_new + 1'b1;
                    wpos_new    = '0;
                end
                n_count[r_ring] = cnt_new;
                n_wpos[r_ring]  = wpos_new;
            end else begin
                if (cnt == '0) begin
                    n_rsp.status = lmr_pkg::ST_EMPTY;
                end else begin
                    n_rsp.data_out = i_store_rdata;
                    if (rpos_inc >= i_len_rdata) begin
                        n_rsp.last_byte = 1'b1;
                        n_head[r_ring]  = head_nx;
                        n_count[r_ring] = cnt - 1'b1;
                        n_rpos[r_ring]  = '0;
                    end else begin
                        n_rpos[r_ring] = rpos_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmr_pkg::S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_wpos[i]  <= '0;
                r_rpos[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_head  <= n_head;
            r_count <= n_count;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_ring <= in_ring;
        end
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- sim/lmr_checker.sv -----
module lmr_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  lmr_pkg::t_req i_req,
    input  logic          i_valid,
    input  lmr_pkg::t_rsp i_rsp,
    input  logic          i_end_check,
    output int            o_fail_count,
    output int            o_pending
);
    import lmr_pkg::*;

    // shadow copy of both rings
    logic [7:0]        ring_mem [2][SLOTS][MSG_BYTES];
    logic [POS_W-1:0]  ring_len [2][SLOTS];
    logic [SLOT_W-1:0] ring_head [2];
    logic [CNT_W-1:0]  ring_cnt [2];
    logic [POS_W-1:0]  wr_pos [2];
    logic [POS_W-1:0]  rd_pos [2];

    t_rsp rsp_expected [$];
    bit   end_checked = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic flag_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= 40)
            $display("error: %s", msg);
    endtask

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    function automatic t_rsp ring_step(input t_req w);
        t_rsp             r;
        int               ring;
        int               slot;
        logic [SLOT_W-1:0] h;
        logic [POS_W-1:0] pos;
        r = '0;
        r.status = ST_OK;
        if (w.command == CMD_SEND) begin
            ring = (w.channel == 1'b1) ? 0 : 1;
            // first byte of a new message into a full ring pushes out the oldest
            if (wr_pos[ring] == '0 && ring_cnt[ring] >= SLOTS_C) begin
                ring_head[ring] = next_slot(ring_head[ring]);
                ring_cnt[ring]  = ring_cnt[ring] - 1'b1;
                rd_pos[ring]    = '0;
                r.status        = ST_DROP;
            end
            slot = (int'(ring_head[ring]) + int'(ring_cnt[ring])) % SLOTS;
            if (wr_pos[ring] < MSG_BYTES_C) begin
                ring_mem[ring][slot][wr_pos[ring]] = w.data_in;
                wr_pos[ring] = wr_pos[ring] + 1'b1;
            end else begin
                r.status = ST_TRUNC;
            end
            if (w.end_of_message) begin
                ring_len[ring][slot] = wr_pos[ring];
                ring_cnt[ring]       = ring_cnt[ring] + 1'b1;
                wr_pos[ring]         = '0;
            end
        end else begin
            ring = (w.channel == 1'b1) ? 1 : 0;
            if (ring_cnt[ring] == '0) begin
                r.status = ST_EMPTY;
            end else begin
                h = ring_head[ring];
                r.data_out = ring_mem[ring][h][rd_pos[ring]];
                pos = rd_pos[ring] + 1'b1;
                if (pos >= ring_len[ring][h]) begin
                    r.last_byte     = 1'b1;
                    ring_head[ring] = next_slot(h);
                    ring_cnt[ring]  = ring_cnt[ring] - 1'b1;
                    rd_pos[ring]    = '0;
                end else begin
                    rd_pos[ring] = pos;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                ring_head[k] = '0;
                ring_cnt[k]  = '0;
                wr_pos[k]    = '0;
                rd_pos[k]    = '0;
            end
            rsp_expected.delete();
        end else begin
            // retire the result first, it always belongs to an older word
            if (i_valid) begin
                if (rsp_expected.size() == 0) begin
                    flag_error($sformatf("unexpected result data=%0h last=%0b status=%0d",
                                         i_rsp.data_out, i_rsp.last_byte, i_rsp.status));
                end else begin
                    want = rsp_expected.pop_front();
                    if (i_rsp.data_out !== want.data_out)
                        flag_error($sformatf("data_out got %0h want %0h",
                                             i_rsp.data_out, want.data_out));
                    if (i_rsp.last_byte !== want.last_byte)
                        flag_error($sformatf("last_byte got %0b want %0b",
                                             i_rsp.last_byte, want.last_byte));
                    if (i_rsp.status !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             i_rsp.status, want.status));
                end
            end
            if (i_start && !i_busy)
                rsp_expected.push_back(ring_step(i_req));
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                if (rsp_expected.size() != 0)
                    flag_error($sformatf("%0d results never arrived", rsp_expected.size()));
            end
        end
        o_pending = rsp_expected.size();
    end

endmodule

// ----- sim/tb_loopback_message_ring_top.sv -----
module tb_loopback_message_ring_top;
    import lmr_pkg::*;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic start     = 1'b0;
    t_req req       = '0;
    logic end_check = 1'b0;
    logic busy;
    logic rsp_valid;
    t_rsp rsp;

    logic word_taken = 1'b0;
    bit   no_idle    = 1'b0;
    int   msg_left [2];
    int   fail_count;
    int   pending;

    loopback_message_ring_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_valid (rsp_valid),
        .o_rsp   (rsp)
    );

    lmr_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_valid      (rsp_valid),
        .i_rsp        (rsp),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        word_taken <= i_rst_n && start && !busy;
    end

    initial begin
        #(8 * 400000);
        $display("tb_loopback_message_ring_top NOT OK");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic issue(input logic cmd, input logic ch, input logic [7:0] data,
                         input logic eom);
        int gap;
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req   <= '{command: cmd, channel: ch, data_in: data, end_of_message: eom};
        start <= 1'b1;
        do @(negedge i_clk); while (!word_taken);
    endtask

    // random sends and receives; sends form mostly well-formed messages with random content, some broken framing
    task automatic random_word(input int recv_pct);
        logic ch;
        logic eom;
        ch = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < recv_pct) begin
            issue(CMD_RECV, ch, 8'($urandom), 1'($urandom));
        end else begin
            if (msg_left[ch] == 0)
                msg_left[ch] = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
            eom = (msg_left[ch] == 1);
            if ($urandom_range(0, 19) == 0)
                eom = !eom;
            msg_left[ch] = eom ? 0 : msg_left[ch] - 1;
            issue(CMD_SEND, ch, 8'($urandom), eom);
        end
    endtask

    initial begin
        int recv_mix [5];
        recv_mix = '{50, 15, 70, 35, 85};
        msg_left = '{0, 0};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty rings, ignored fields set
        issue(CMD_RECV, 1'b0, 8'hFF, 1'b1);
        issue(CMD_RECV, 1'b1, 8'h00, 1'b0);
        // two byte message into ring 1, read halfway
        issue(CMD_SEND, 1'b0, 8'h00, 1'b0);
        issue(CMD_SEND, 1'b0, 8'hFF, 1'b1);
        issue(CMD_RECV, 1'b1, 8'h00, 1'b0);
        // fill the ring, then drop the partly read oldest message
        issue(CMD_SEND, 1'b0, 8'hA5, 1'b1);
        issue(CMD_SEND, 1'b0, 8'h5A, 1'b1);
        issue(CMD_SEND, 1'b0, 8'h3C, 1'b1);
        issue(CMD_SEND, 1'b0, 8'hC3, 1'b0);
        issue(CMD_SEND, 1'b0, 8'h81, 1'b1);
        repeat (6) issue(CMD_RECV, 1'b1, 8'h00, 1'b0);
        // other direction, single byte message
        issue(CMD_SEND, 1'b1, 8'h7E, 1'b1);
        issue(CMD_RECV, 1'b0, 8'h00, 1'b0);
        issue(CMD_RECV, 1'b0, 8'h00, 1'b0);

        foreach (recv_mix[p])
            repeat (110) random_word(recv_mix[p]);

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_loopback_message_ring_top OK");
        end else begin
            $display("tb_loopback_message_ring_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lmr_pkg.sv
rtl/lmr_ram.sv
rtl/lmr_ctrl.sv
rtl/loopback_message_ring_top.sv
sim/lmr_checker.sv
sim/tb_loopback_message_ring_top.sv
